[src/bc3_block_decoder_defines.svh]
// assertion macros shared by the decoder rtl
`ifndef BC3_BLOCK_DECODER_DEFINES_SVH
`define BC3_BLOCK_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every clock outside reset
`define BC3_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition in one cycle implies a property in the next
`define BC3_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define BC3_ASSERT(label, prop, msg)
`define BC3_ASSERT_NEXT(label, cond, prop, msg)

`endif

`endif

[src/bc3_pkg.sv]
package bc3_pkg;

    // image and tile geometry
    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int COL_W     = 10;
    localparam int TILE_W    = COL_W + 1;
    localparam int POS_W     = 12;
    localparam int CH_W      = 8;
    localparam int HALF_W    = 64;
    localparam int TEXELS    = 16;
    localparam int TIDX_W    = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // queue between front and back
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // reciprocals for division by small constants
    localparam int RCP3  = ((1 << 11) + 2) / 3;
    localparam int RCP5  = ((1 << 14) + 4) / 5;
    localparam int RCP7  = ((1 << 14) + 6) / 7;
    localparam int RCP31 = ((1 << 18) + 30) / 31;
    localparam int RCP63 = ((1 << 20) + 62) / 63;
    localparam int EXP5_K = 255 * RCP31;
    localparam int EXP6_K = 255 * RCP63;

    // block after classification, before palette division
    typedef struct packed {
        logic [POS_W-1:0]               base_x;
        logic [POS_W-1:0]               base_y;
        logic [TEXELS-1:0]              mask;
        logic [TEXELS-1:0]              end_mask;
        logic [TEXELS-1:0][2:0]         aidx;
        logic [TEXELS-1:0][1:0]         cidx;
        logic [CH_W-1:0]                a0;
        logic [CH_W-1:0]                a1;
        logic                           sevenths;
        logic [5:0][10:0]               anum;
        logic [1:0][2:0][CH_W-1:0]      cend;
        logic [1:0][2:0][9:0]           cnum;
    } t_pre;

    // block with full palettes, as queued for the back end
    typedef struct packed {
        logic [POS_W-1:0]               base_x;
        logic [POS_W-1:0]               base_y;
        logic [TEXELS-1:0]              mask;
        logic [TEXELS-1:0]              end_mask;
        logic [TEXELS-1:0][2:0]         aidx;
        logic [TEXELS-1:0][1:0]         cidx;
        logic [7:0][CH_W-1:0]           apal;
        logic [3:0][2:0][CH_W-1:0]      cpal;
    } t_blk;

    // one decoded texel
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [CH_W-1:0]  r;
        logic [CH_W-1:0]  g;
        logic [CH_W-1:0]  b;
        logic [CH_W-1:0]  a;
        logic             block_end;
        logic             image_end;
    } t_texel;

    // zero reads as one, oversize reads as the largest size
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // x * 255 / 31, truncated
    function automatic logic [CH_W-1:0] exp5(input logic [4:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'(EXP5_K);
        return CH_W'(p >> 18);
    endfunction

    // x * 255 / 63, truncated
    function automatic logic [CH_W-1:0] exp6(input logic [5:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'(EXP6_K);
        return CH_W'(p >> 20);
    endfunction

    function automatic logic [CH_W-1:0] div3(input logic [9:0] v);
        logic [19:0] p;
        p = 20'(v) * 20'(RCP3);
        return CH_W'(p >> 11);
    endfunction

    function automatic logic [CH_W-1:0] div5(input logic [10:0] v);
        logic [22:0] p;
        p = 23'(v) * 23'(RCP5);
        return CH_W'(p >> 14);
    endfunction

    function automatic logic [CH_W-1:0] div7(input logic [10:0] v);
        logic [22:0] p;
        p = 23'(v) * 23'(RCP7);
        return CH_W'(p >> 14);
    endfunction

endpackage

[src/bc3_block_decoder.sv]
// channel  | direction | handshake         | words
// ---------+-----------+-------------------+---------------------------------------
// block    | in        | push / full       | i_alpha_half, i_color_half
// texel    | out       | empty / pop       | o_pixel_x/y, o_red..o_alpha, ends
// config   | in        | i_cfg_we          | i_cfg_idx, i_cfg_wdata
//
// a queued block has 1 to 16 texels inside the image, and the back end sends them
// one texel a cycle from the output register while the texel side pops
// a block with no texels inside the image is dropped by the front end, never queued
// the front end classifies a block into a register and divides its palettes on the
// way into a two-word queue, so it can take the next block while the back end sends
// synchronous active-low reset: 4x4 image size, clear tile counters, queue, valids
// full rises only when the queue is full and the front stage holds texels to queue

module bc3_block_decoder import bc3_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [HALF_W-1:0]    i_alpha_half,
    input  logic [HALF_W-1:0]    i_color_half,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_wdata,
    output logic                 empty,
    input  logic                 pop,
    output logic [POS_W-1:0]     o_pixel_x,
    output logic [POS_W-1:0]     o_pixel_y,
    output logic [CH_W-1:0]      o_red,
    output logic [CH_W-1:0]      o_green,
    output logic [CH_W-1:0]      o_blue,
    output logic [CH_W-1:0]      o_alpha,
    output logic                 o_block_end,
    output logic                 o_image_end
);

    logic   q_push, q_full, q_pop, q_empty;
    t_blk   q_wdata, q_rdata;
    t_texel texel;

    // front: classify blocks and build palettes
    bc3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_alpha_half (i_alpha_half),
        .i_color_half (i_color_half),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_q_push     (q_push),
        .i_q_full     (q_full),
        .o_q_data     (q_wdata)
    );

    // block queue between front and back
    bc3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // back: send texels one a cycle while the texel side pops
    bc3_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_texel   (texel)
    );

    assign o_pixel_x   = texel.x;
    assign o_pixel_y   = texel.y;
    assign o_red       = texel.r;
    assign o_green     = texel.g;
    assign o_blue      = texel.b;
    assign o_alpha     = texel.a;
    assign o_block_end = texel.block_end;
    assign o_image_end = texel.image_end;

endmodule

[src/bc3_front.sv]
`include "bc3_block_decoder_defines.svh"

module bc3_front import bc3_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [HALF_W-1:0]    i_alpha_half,
    input  logic [HALF_W-1:0]    i_color_half,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_wdata,
    output logic                 o_q_push,
    input  logic                 i_q_full,
    output t_blk                 o_q_data
);

    logic [DIM_W-1:0]  r_width, r_height;
    logic [COL_W-1:0]  r_col, r_row, n_col, n_row;
    t_pre              r_pre, n_pre;
    logic              r_pre_vld, n_pre_vld;

    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [TILE_W-1:0] bx_cnt, by_cnt;
    logic [POS_W-1:0]  x_base, y_base;
    logic [3:0]        col_ok, row_ok, col_end, row_end;
    logic              accept, stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(4);
            r_height <= DIM_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // tile counts and position of the incoming block
    assign w_eff  = eff_dim(r_width);
    assign h_eff  = eff_dim(r_height);
    assign bx_cnt = TILE_W'((w_eff + DIM_W'(3)) >> 2);
    assign by_cnt = TILE_W'((h_eff + DIM_W'(3)) >> 2);
    assign x_base = {r_col, 2'b00};
    assign y_base = {r_row, 2'b00};

    // which columns and rows of the tile fall inside the image
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            col_ok[j]  = (DIM_W'(x_base) + DIM_W'(j)) < w_eff;
            row_ok[j]  = (DIM_W'(y_base) + DIM_W'(j)) < h_eff;
            col_end[j] = (DIM_W'(x_base) + DIM_W'(j)) == (w_eff - DIM_W'(1));
            row_end[j] = (DIM_W'(y_base) + DIM_W'(j)) == (h_eff - DIM_W'(1));
        end
    end

    // handshake: stage holds while a block with texels waits on the queue
    assign stall    = r_pre_vld && (r_pre.mask != '0) && i_q_full;
    assign o_full   = stall;
    assign accept   = i_push && !stall;
    assign o_q_push = r_pre_vld && (r_pre.mask != '0) && !i_q_full;

    // classify the block and form palette numerators
    always_comb begin
        n_pre = r_pre;
        if (accept) begin
            n_pre.base_x   = x_base;
            n_pre.base_y   = y_base;
            for (int i = 0; i < TEXELS; i++) begin
                n_pre.mask[i]     = col_ok[i % 4] && row_ok[i / 4];
                n_pre.end_mask[i] = col_end[i % 4] && row_end[i / 4];
            end
            n_pre.aidx     = i_alpha_half[HALF_W-1:16];
            n_pre.cidx     = i_color_half[HALF_W-1:32];
            n_pre.a0       = i_alpha_half[7:0];
            n_pre.a1       = i_alpha_half[15:8];
            n_pre.sevenths = i_alpha_half[7:0] > i_alpha_half[15:8];
            for (int i = 1; i <= 6; i++) begin
                if (i_alpha_half[7:0] > i_alpha_half[15:8]) begin
                    n_pre.anum[i-1] = 11'((7 - i) * i_alpha_half[7:0]
                                          + i * i_alpha_half[15:8]);
                end else if (i <= 4) begin
                    n_pre.anum[i-1] = 11'((5 - i) * i_alpha_half[7:0]
                                          + i * i_alpha_half[15:8]);
                end else begin
                    n_pre.anum[i-1] = '0;
                end
            end
            n_pre.cend[0][0] = exp5(i_color_half[15:11]);
            n_pre.cend[0][1] = exp6(i_color_half[10:5]);
            n_pre.cend[0][2] = exp5(i_color_half[4:0]);
            n_pre.cend[1][0] = exp5(i_color_half[31:27]);
            n_pre.cend[1][1] = exp6(i_color_half[26:21]);
            n_pre.cend[1][2] = exp5(i_color_half[20:16]);
            for (int k = 0; k < 3; k++) begin
                n_pre.cnum[0][k] = 10'(2 * n_pre.cend[0][k] + n_pre.cend[1][k]);
                n_pre.cnum[1][k] = 10'(n_pre.cend[0][k] + 2 * n_pre.cend[1][k]);
            end
        end
    end

    // stage valid and tile counters
    always_comb begin
        n_pre_vld = r_pre_vld;
        n_col     = r_col;
        n_row     = r_row;
        if (accept) begin
            n_pre_vld = 1'b1;
            if ((TILE_W'(r_col) + TILE_W'(1)) >= bx_cnt) begin
                n_col = '0;
                if ((TILE_W'(r_row) + TILE_W'(1)) >= by_cnt) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + COL_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end else if (!stall) begin
            n_pre_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_vld <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            r_pre_vld <= n_pre_vld;
            r_col     <= n_col;
            r_row     <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre <= n_pre;
    end

    // finish palettes: divide numerators by constants
    always_comb begin
        o_q_data.base_x   = r_pre.base_x;
        o_q_data.base_y   = r_pre.base_y;
        o_q_data.mask     = r_pre.mask;
        o_q_data.end_mask = r_pre.end_mask;
        o_q_data.aidx     = r_pre.aidx;
        o_q_data.cidx     = r_pre.cidx;
        o_q_data.apal[0]  = r_pre.a0;
        o_q_data.apal[1]  = r_pre.a1;
        for (int i = 0; i < 6; i++) begin
            if (r_pre.sevenths) begin
                o_q_data.apal[i+2] = div7(r_pre.anum[i]);
            end else if (i < 4) begin
                o_q_data.apal[i+2] = div5(r_pre.anum[i]);
            end else if (i == 4) begin
                o_q_data.apal[i+2] = '0;
            end else begin
                o_q_data.apal[i+2] = CH_W'(255);
            end
        end
        o_q_data.cpal[0] = r_pre.cend[0];
        o_q_data.cpal[1] = r_pre.cend[1];
        for (int k = 0; k < 3; k++) begin
            o_q_data.cpal[2][k] = div3(r_pre.cnum[0][k]);
            o_q_data.cpal[3][k] = div3(r_pre.cnum[1][k]);
        end
    end

    // checks
    `BC3_ASSERT(a_front_push_has_texels, o_q_push |-> (r_pre.mask != '0), "empty block queued")
    `BC3_ASSERT_NEXT(a_front_stall_holds, stall, r_pre_vld && $stable(r_pre), "stalled block lost")

endmodule

[src/bc3_queue.sv]
`include "bc3_block_decoder_defines.svh"

module bc3_queue import bc3_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_blk i_data,
    input  logic i_pop,
    output logic o_empty,
    output t_blk o_data
);

    t_blk                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr, r_rd;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic                do_push, do_pop;

    assign o_full  = r_cnt == Q_CNT_W'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // pointers wrap at the queue depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // checks
    `BC3_ASSERT(a_queue_no_overflow, i_push |-> !o_full, "block pushed into full queue")

endmodule

[src/bc3_back.sv]
`include "bc3_block_decoder_defines.svh"

module bc3_back import bc3_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_empty,
    input  t_blk   i_q_data,
    output logic   o_q_pop,
    output logic   o_empty,
    input  logic   i_pop,
    output t_texel o_texel
);

    t_blk               r_cur;
    logic               r_cur_vld;
    logic [TEXELS-1:0]  r_rem, rem_nx;
    t_texel             r_out, texel;
    logic               r_out_vld;

    logic [TIDX_W-1:0]  idx;
    logic [2:0]         ai;
    logic [1:0]         ci;
    logic               out_free, emit, last, load;

    // lowest texel still to be sent
    always_comb begin
        idx = '0;
        for (int i = TEXELS - 1; i >= 0; i--) begin
            if (r_rem[i]) begin
                idx = TIDX_W'(i);
            end
        end
    end

    assign rem_nx   = r_rem & ~(TEXELS'(1) << idx);
    assign last     = rem_nx == '0;
    assign out_free = !r_out_vld || i_pop;
    assign emit     = r_cur_vld && out_free;
    assign load     = !i_q_empty && (!r_cur_vld || (emit && last));
    assign o_q_pop  = load;

    // palette lookup for the selected texel
    assign ai = r_cur.aidx[idx];
    assign ci = r_cur.cidx[idx];

    always_comb begin
        texel.x         = {r_cur.base_x[POS_W-1:2], idx[1:0]};
        texel.y         = {r_cur.base_y[POS_W-1:2], idx[3:2]};
        texel.r         = r_cur.cpal[ci][0];
        texel.g         = r_cur.cpal[ci][1];
        texel.b         = r_cur.cpal[ci][2];
        texel.a         = r_cur.apal[ai];
        texel.block_end = last;
        texel.image_end = r_cur.end_mask[idx];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_rem     <= '0;
        end else begin
            if (load) begin
                r_cur_vld <= 1'b1;
                r_rem     <= i_q_data.mask;
            end else if (emit) begin
                r_cur_vld <= !last;
                r_rem     <= rem_nx;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_data;
        end
        if (emit) begin
            r_out <= texel;
        end
    end

    assign o_empty = !r_out_vld;
    assign o_texel = r_out;

    // checks
    `BC3_ASSERT(a_back_busy_has_texels, r_cur_vld |-> (r_rem != '0), "active block with no texels")
    `BC3_ASSERT(a_back_pop_not_empty, o_q_pop |-> !i_q_empty, "pop from empty queue")

endmodule

[tb/sv/bc3_block_decoder_tb.sv]
`timescale 1ns / 1ps

module bc3_block_decoder_tb;
    import bc3_pkg::*;

    localparam int     CLK_HALF         = 4;
    localparam int     RESET_CYCLES     = 12;
    localparam int     SETTLE_CYCLES    = 40;
    localparam int     RANDOM_PHASES    = 12;
    localparam int     BLOCKS_PER_PHASE = 40;
    localparam int     MAX_GAP          = 8;
    localparam int     DIM_MAX_CODE     = (1 << DIM_W) - 1;
    localparam longint CYCLE_LIMIT      = 1000000;

    typedef enum logic {STEP_BLOCK, STEP_CFG} t_step_kind;

    // one row of the directed plan: a block word or a register write
    typedef struct {
        t_step_kind           kind;
        logic [HALF_W-1:0]    ah;
        logic [HALF_W-1:0]    ch;
        logic                 fixed;
        logic [CH_W-1:0]      r;
        logic [CH_W-1:0]      g;
        logic [CH_W-1:0]      b;
        logic [CH_W-1:0]      a;
        logic [CFG_IDX_W-1:0] idx;
        logic [DIM_W-1:0]     val;
    } t_step;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [HALF_W-1:0]    i_alpha_half = '0;
    logic [HALF_W-1:0]    i_color_half = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DIM_W-1:0]     i_cfg_wdata = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [POS_W-1:0]     o_pixel_x;
    logic [POS_W-1:0]     o_pixel_y;
    logic [CH_W-1:0]      o_red;
    logic [CH_W-1:0]      o_green;
    logic [CH_W-1:0]      o_blue;
    logic [CH_W-1:0]      o_alpha;
    logic                 o_block_end;
    logic                 o_image_end;

    // decoder copy of the image size and tile position
    logic [DIM_W-1:0]     img_w = DIM_W'(4);
    logic [DIM_W-1:0]     img_h = DIM_W'(4);
    logic [COL_W-1:0]     tile_col = '0;
    logic [COL_W-1:0]     tile_row = '0;
    t_texel               texels_due[$];

    int                   errors = 0;
    longint               cycles = 0;
    bit                   send_burst = 1'b0;
    bit                   take_burst = 1'b0;

    bc3_block_decoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_alpha_half (i_alpha_half),
        .i_color_half (i_color_half),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .empty        (empty),
        .pop          (pop),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_block_end  (o_block_end),
        .o_image_end  (o_image_end)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // decode one block into texels, then step the tile position
    task automatic decode_block(input logic [HALF_W-1:0] ah, input logic [HALF_W-1:0] ch,
                                input logic fixed, input logic [CH_W-1:0] fr,
                                input logic [CH_W-1:0] fg, input logic [CH_W-1:0] fb,
                                input logic [CH_W-1:0] fa);
        int          w, h, tiles_x, tiles_y, a0, a1, x, y, ci, ai, i, k;
        int          apal[8];
        int          cpal[4][3];
        logic [15:0] c565;
        t_texel      tx;
        t_texel      blk[$];

        // zero size reads as one, oversize as the largest
        w = (img_w == 0) ? 1 : (int'(img_w) > MAX_DIM) ? MAX_DIM : int'(img_w);
        h = (img_h == 0) ? 1 : (int'(img_h) > MAX_DIM) ? MAX_DIM : int'(img_h);
        tiles_x = (w + 3) / 4;
        tiles_y = (h + 3) / 4;

        // alpha palette: sevenths, or fifths with 0 and 255 on top
        a0 = int'(ah[7:0]);
        a1 = int'(ah[15:8]);
        apal[0] = a0;
        apal[1] = a1;
        if (a0 > a1) begin
            for (i = 1; i <= 6; i++) apal[i + 1] = ((7 - i) * a0 + i * a1) / 7;
        end else begin
            for (i = 1; i <= 4; i++) apal[i + 1] = ((5 - i) * a0 + i * a1) / 5;
            apal[6] = 0;
            apal[7] = 255;
        end

        // colour palette: 565 endpoints widened, two thirds in between
        for (i = 0; i < 2; i++) begin
            c565 = ch[16 * i +: 16];
            cpal[i][0] = int'(c565[15:11]) * 255 / 31;
            cpal[i][1] = int'(c565[10:5]) * 255 / 63;
            cpal[i][2] = int'(c565[4:0]) * 255 / 31;
        end
        for (k = 0; k < 3; k++) begin
            cpal[2][k] = (2 * cpal[0][k] + cpal[1][k]) / 3;
            cpal[3][k] = (cpal[0][k] + 2 * cpal[1][k]) / 3;
        end

        // texels inside the image, row by row
        for (i = 0; i < TEXELS; i++) begin
            x = int'(tile_col) * 4 + (i % 4);
            y = int'(tile_row) * 4 + (i / 4);
            if (x >= w || y >= h) continue;
            ci = int'(ch[32 + 2 * i +: 2]);
            ai = int'(ah[16 + 3 * i +: 3]);
            tx.x = POS_W'(x);
            tx.y = POS_W'(y);
            tx.r = fixed ? fr : CH_W'(cpal[ci][0]);
            tx.g = fixed ? fg : CH_W'(cpal[ci][1]);
            tx.b = fixed ? fb : CH_W'(cpal[ci][2]);
            tx.a = fixed ? fa : CH_W'(apal[ai]);
            tx.block_end = 1'b0;
            tx.image_end = (x == w - 1 && y == h - 1);
            blk.push_back(tx);
        end
        if (blk.size() > 0) blk[blk.size() - 1].block_end = 1'b1;
        foreach (blk[n]) texels_due.push_back(blk[n]);

        // raster step, wrapping at the last tile
        if (int'(tile_col) + 1 >= tiles_x) begin
            tile_col = '0;
            if (int'(tile_row) + 1 >= tiles_y) tile_row = '0;
            else tile_row = tile_row + 1'b1;
        end else begin
            tile_col = tile_col + 1'b1;
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // hand one block word to the decoder
    task automatic send_block(input logic [HALF_W-1:0] ah, input logic [HALF_W-1:0] ch,
                              input logic fixed, input logic [CH_W-1:0] fr,
                              input logic [CH_W-1:0] fg, input logic [CH_W-1:0] fb,
                              input logic [CH_W-1:0] fa);
        int gap;
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_alpha_half <= ah;
        i_color_half <= ch;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_block(ah, ch, fixed, fr, fg, fb, fa);
    endtask

    // wait until every expected texel is out and the pipe has gone quiet
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (texels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == REG_IMAGE_WIDTH) img_w = val;
        else if (idx == REG_IMAGE_HEIGHT) img_h = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random block, leaning toward equal and extreme endpoints now and then
    function automatic void random_block(output logic [HALF_W-1:0] ah,
                                         output logic [HALF_W-1:0] ch);
        ah = {$urandom, $urandom};
        ch = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: ah[15:8] = ah[7:0];
            1: ah[7:0] = 8'h00;
            2: ah[7:0] = 8'hFF;
            3: ah[15:8] = 8'h00;
            4: ah[15:8] = 8'hFF;
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: ch[31:16] = ch[15:0];
            1: ch[15:0] = 16'h0000;
            2: ch[15:0] = 16'hFFFF;
            3: ch[31:16] = 16'hFFFF;
            default: ;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DIM_W'(1);
            2: return DIM_W'($urandom_range(MAX_DIM + 1, DIM_MAX_CODE));
            3: return DIM_W'(MAX_DIM);
            default: return DIM_W'($urandom_range(2, 24));
        endcase
    endfunction

    // new image size, then a run of random blocks
    task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input int count);
        logic [HALF_W-1:0] ah, ch;
        drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        repeat (count) begin
            random_block(ah, ch);
            send_block(ah, ch, 1'b0, '0, '0, '0, '0);
        end
    endtask

    function automatic t_step blk_row(input logic [HALF_W-1:0] ah,
                                      input logic [HALF_W-1:0] ch);
        t_step s;
        s.kind = STEP_BLOCK;
        s.ah = ah;
        s.ch = ch;
        s.fixed = 1'b0;
        s.r = '0;
        s.g = '0;
        s.b = '0;
        s.a = '0;
        s.idx = '0;
        s.val = '0;
        return s;
    endfunction

    // block whose texels all share one known colour
    function automatic t_step solid_row(input logic [HALF_W-1:0] ah,
                                        input logic [HALF_W-1:0] ch,
                                        input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                        input logic [CH_W-1:0] b, input logic [CH_W-1:0] a);
        t_step s;
        s = blk_row(ah, ch);
        s.fixed = 1'b1;
        s.r = r;
        s.g = g;
        s.b = b;
        s.a = a;
        return s;
    endfunction

    function automatic t_step cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DIM_W-1:0] val);
        t_step s;
        s = blk_row('0, '0);
        s.kind = STEP_CFG;
        s.idx = idx;
        s.val = val;
        return s;
    endfunction

    // texel sink: random pop gaps, check each word against the oldest due
    initial begin : texel_sink
        int     gap;
        t_texel want;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
            gap = take_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                @(negedge i_clk);
                pop <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            if (texels_due.size() == 0) begin
                $error("texel at (%0d,%0d) with nothing due", o_pixel_x, o_pixel_y);
                errors++;
            end else begin
                want = texels_due.pop_front();
                check_field("pixel_x", want.x, o_pixel_x);
                check_field("pixel_y", want.y, o_pixel_y);
                check_field("red", want.r, o_red);
                check_field("green", want.g, o_green);
                check_field("blue", want.b, o_blue);
                check_field("alpha", want.a, o_alpha);
                check_field("block_end", want.block_end, o_block_end);
                check_field("image_end", want.image_end, o_image_end);
            end
        end
    end

    // stimulus: directed plan, then random phases
    initial begin : stimulus
        t_step plan[$];

        // solid blocks on the reset 4x4 image
        plan.push_back(solid_row('0, '0, 8'd0, 8'd0, 8'd0, 8'd0));
        plan.push_back(solid_row('1, '1, 8'd255, 8'd255, 8'd255, 8'd255));
        plan.push_back(solid_row({48'h0, 8'h00, 8'h80}, {32'h0, 16'h0000, 16'hF800},
                                 8'd255, 8'd0, 8'd0, 8'd128));
        plan.push_back(solid_row({48'h249249249249, 8'h40, 8'h00},
                                 {32'h55555555, 16'h07E0, 16'h0000},
                                 8'd0, 8'd255, 8'd0, 8'd64));
        // fifths palette, index 6 is the appended zero
        plan.push_back(solid_row({48'hDB6DB6DB6DB6, 8'hFF, 8'h00},
                                 {32'h0, 16'h0000, 16'h001F},
                                 8'd0, 8'd0, 8'd255, 8'd0));
        // every palette entry of both kinds
        plan.push_back(blk_row({48'hFAC688FAC688, 8'h10, 8'hF0},
                               {32'hE4E4E4E4, 16'h07E0, 16'hF81F}));
        plan.push_back(blk_row({48'hFAC688FAC688, 8'hF0, 8'h10},
                               {32'h1B1B1B1B, 16'hFFFF, 16'h0000}));
        plan.push_back(blk_row({48'hFAC688FAC688, 8'h80, 8'h80},
                               {32'hE4E4E4E4, 16'h1234, 16'h1234}));
        plan.push_back(blk_row({48'h053977FAC688, 8'h00, 8'hFF},
                               {32'h9C9C9C9C, 16'h0000, 16'hFFFF}));
        // partial tiles on a 5x7 image
        plan.push_back(cfg_row(REG_IMAGE_WIDTH, DIM_W'(5)));
        plan.push_back(cfg_row(REG_IMAGE_HEIGHT, DIM_W'(7)));
        plan.push_back(blk_row(64'h8E3A_51C7_29B4_6DF0, 64'h3C5A_96E1_7B28_D40F));
        plan.push_back(blk_row(64'h1F2E_3D4C_5B6A_7988, 64'hA5A5_5A5A_F00F_0FF0));
        plan.push_back(blk_row(64'hC0FF_EE12_3456_7F01, 64'h6996_C33C_8421_1248));
        plan.push_back(blk_row(64'h7777_BBBB_DDDD_20E0, 64'hEDB7_1248_FFE0_001F));
        // zero size reads as a single pixel
        plan.push_back(cfg_row(REG_IMAGE_WIDTH, '0));
        plan.push_back(cfg_row(REG_IMAGE_HEIGHT, '0));
        plan.push_back(blk_row(64'hFFFF_FFFF_FFFF_00FF, 64'hFFFF_FFFF_F800_07E0));
        // oversize clamps to the largest image
        plan.push_back(cfg_row(REG_IMAGE_WIDTH, DIM_W'(DIM_MAX_CODE)));
        plan.push_back(cfg_row(REG_IMAGE_HEIGHT, DIM_W'(DIM_MAX_CODE)));
        plan.push_back(blk_row(64'h2468_ACE1_3579_BDF0, 64'h0F1E_2D3C_4B5A_6978));
        // shrink leaves the tile column outside the image: nothing, then wrap
        plan.push_back(cfg_row(REG_IMAGE_WIDTH, DIM_W'(4)));
        plan.push_back(cfg_row(REG_IMAGE_HEIGHT, DIM_W'(4)));
        plan.push_back(blk_row(64'hDEAD_BEEF_0BAD_F00D, 64'h1357_9BDF_0246_8ACE));
        plan.push_back(blk_row(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[s]) begin
            if (plan[s].kind == STEP_CFG) begin
                drain();
                write_reg(plan[s].idx, plan[s].val);
            end else begin
                send_block(plan[s].ah, plan[s].ch, plan[s].fixed,
                           plan[s].r, plan[s].g, plan[s].b, plan[s].a);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            run_phase(pick_size(), pick_size(), BLOCKS_PER_PHASE);
        end

        drain();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/bc3_pkg.sv
src/bc3_front.sv
src/bc3_queue.sv
src/bc3_back.sv
src/bc3_block_decoder.sv
tb/sv/bc3_block_decoder_tb.sv
